>>> rtl/pdrt_pkg.sv
// Package for the duplicate packet route table.
// Holds the command and status codes and the entry, query and search hit types.
`default_nettype none
package pdrt_pkg;

    localparam logic [2:0] CMD_INSERT      = 3'd0;
    localparam logic [2:0] CMD_REMOVE      = 3'd1;
    localparam logic [2:0] CMD_FIND        = 3'd2;
    localparam logic [2:0] CMD_HOP_OF_NODE = 3'd3;
    localparam logic [2:0] CMD_NODE_OF_HOP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] node;
        logic [15:0] prev_hop;
        logic [31:0] seq;
        logic [7:0]  hops;
    } t_entry;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] node;
        logic [15:0] hop;
        logic [31:0] seq;
        logic [7:0]  hops;
    } t_query;

    typedef struct packed {
        logic        found;
        logic [15:0] addr;
        logic [7:0]  hops;
    } t_hit;

endpackage
`default_nettype wire

>>> rtl/packet_duplicate_route_table.sv
// Duplicate packet route table: a row of slot cells in arrival order, a
// registered priority tree that finds the oldest match, and the command control.
// Uses pdrt_pkg, pdrt_cell and pdrt_pick.
//
// Input channel (i_in_valid / o_in_stall) carries one command item; the output
// channel (o_out_valid / i_out_stall) returns one result item per command.
// All slots compare the query at once; the hit of the oldest matching slot is
// then chosen by a tree of clog2(TABLE_ENTRIES) register stages.
// A new item is taken only once the previous result is registered and the
// control is back in idle, so one item at a time passes the search tree.
// Removal closes the gap: every slot at or after the removed one
// takes the contents of its neighbor.
// Reset empties the table at once. A stalled result holds in the output
// register while the next item is searched; that item then waits before its
// table update until the result is taken.
`default_nettype none
module packet_duplicate_route_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_node_addr,
    input  wire logic [15:0] i_last_hop,
    input  wire logic [31:0] i_seq_num,
    input  wire logic [7:0]  i_hop_count,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_addr,
    output logic [7:0]       o_out_hops,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_entry_count
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int P    = 1 << IW;
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int L    = IW;
    localparam int CNTW = $clog2(L + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    pdrt_pkg::t_query r_query;
    logic [CW-1:0]    r_fill, n_fill;

    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status, n_status;
    logic [15:0]      r_addr, n_addr;
    logic [7:0]       r_hops, n_hops;
    logic [CW-1:0]    r_count, n_count;

    logic             w_accept;
    logic             w_commit;
    logic             w_do_insert;
    logic             w_do_remove;

    logic                   w_valid [TABLE_ENTRIES];
    pdrt_pkg::t_entry       w_entry [TABLE_ENTRIES];
    logic                   w_match [TABLE_ENTRIES];
    pdrt_pkg::t_hit         w_hit   [1:2*P-1];
    logic [IW-1:0]          w_idx   [1:2*P-1];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_commit = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            logic             w_nv;
            pdrt_pkg::t_entry w_ne;
            if (gi == TABLE_ENTRIES - 1) begin : g_last
                assign w_nv = 1'b0;
                assign w_ne = '0;
            end else begin : g_mid
                assign w_nv = w_valid[gi+1];
                assign w_ne = w_entry[gi+1];
            end
            pdrt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (w_do_insert && (r_fill == CW'(gi))),
                .i_shift      (w_do_remove && (IW'(gi) >= w_idx[1])),
                .i_query      (r_query),
                .i_next_valid (w_nv),
                .i_next_entry (w_ne),
                .o_valid      (w_valid[gi]),
                .o_entry      (w_entry[gi]),
                .o_match      (w_match[gi])
            );
        end

        for (gi = 0; gi < P; gi++) begin : g_leaf
            if (gi < TABLE_ENTRIES) begin : g_real
                assign w_hit[P+gi] = '{
                    found: w_match[gi],
                    addr:  (r_query.cmd == pdrt_pkg::CMD_NODE_OF_HOP) ?
                           w_entry[gi].node : w_entry[gi].prev_hop,
                    hops:  w_entry[gi].hops
                };
                assign w_idx[P+gi] = IW'(gi);
            end else begin : g_pad
                assign w_hit[P+gi] = '0;
                assign w_idx[P+gi] = '0;
            end
        end

        for (gi = 1; gi < P; gi++) begin : g_node
            pdrt_pick #(.IW(IW)) u_pick (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_lo_hit (w_hit[2*gi]),
                .i_lo_idx (w_idx[2*gi]),
                .i_hi_hit (w_hit[2*gi+1]),
                .i_hi_idx (w_idx[2*gi+1]),
                .o_hit    (w_hit[gi]),
                .o_idx    (w_idx[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_addr      = r_addr;
        n_hops      = r_hops;
        n_count     = r_count;
        w_do_insert = 1'b0;
        w_do_remove = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SRCH;
                    n_cnt   = '0;
                end
            end
            S_SRCH: begin
                if (r_cnt == CNTW'(L)) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                if (w_commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = pdrt_pkg::ST_MISS;
                    n_addr      = '0;
                    n_hops      = '0;
                    case (r_query.cmd)
                        pdrt_pkg::CMD_INSERT: begin
                            if (w_hit[1].found) begin
                                n_status = pdrt_pkg::ST_MISS;
                            end else if (r_fill == CW'(TABLE_ENTRIES)) begin
                                n_status = pdrt_pkg::ST_FULL;
                            end else begin
                                w_do_insert = 1'b1;
                                n_fill      = r_fill + 1'b1;
                                n_status    = pdrt_pkg::ST_OK;
                            end
                        end
                        pdrt_pkg::CMD_REMOVE: begin
                            if (w_hit[1].found) begin
                                w_do_remove = 1'b1;
                                n_fill      = r_fill - 1'b1;
                                n_status    = pdrt_pkg::ST_OK;
                            end
                        end
                        pdrt_pkg::CMD_FIND: begin
                            if (w_hit[1].found) begin
                                n_status = pdrt_pkg::ST_OK;
                                n_addr   = w_hit[1].addr;
                                n_hops   = w_hit[1].hops;
                            end
                        end
                        pdrt_pkg::CMD_HOP_OF_NODE, pdrt_pkg::CMD_NODE_OF_HOP: begin
                            if (w_hit[1].found) begin
                                n_status = pdrt_pkg::ST_OK;
                                n_addr   = w_hit[1].addr;
                            end
                        end
                        default: begin
                            n_status = pdrt_pkg::ST_MISS;
                        end
                    endcase
                    n_count = n_fill;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query.cmd  <= i_cmd;
            r_query.node <= i_node_addr;
            r_query.hop  <= i_last_hop;
            r_query.seq  <= i_seq_num;
            r_query.hops <= i_hop_count;
        end
        r_status <= n_status;
        r_addr   <= n_addr;
        r_hops   <= n_hops;
        r_count  <= n_count;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_addr    = r_addr;
    assign o_out_hops    = r_hops;
    assign o_entry_count = r_count;

endmodule
`default_nettype wire

>>> rtl/pdrt_cell.sv
// One table slot: holds an entry, compares it against the current query,
// and loads a new entry or takes its neighbor's on removal. Uses pdrt_pkg.
`default_nettype none
module pdrt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic            i_shift,
    input  wire pdrt_pkg::t_query i_query,
    input  wire logic            i_next_valid,
    input  wire pdrt_pkg::t_entry i_next_entry,
    output logic                 o_valid,
    output pdrt_pkg::t_entry     o_entry,
    output logic                 o_match
);

    logic             r_valid;
    pdrt_pkg::t_entry r_entry;
    logic             r_match;
    logic             n_match;

    always_comb begin
        case (i_query.cmd)
            pdrt_pkg::CMD_INSERT, pdrt_pkg::CMD_REMOVE, pdrt_pkg::CMD_FIND: begin
                n_match = (r_entry.node == i_query.node) && (r_entry.seq == i_query.seq);
            end
            pdrt_pkg::CMD_HOP_OF_NODE: begin
                n_match = (r_entry.node == i_query.node);
            end
            pdrt_pkg::CMD_NODE_OF_HOP: begin
                n_match = (r_entry.prev_hop == i_query.hop);
            end
            default: begin
                n_match = 1'b0;
            end
        endcase
        n_match = n_match && r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (i_shift) begin
                r_valid <= i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry.node     <= i_query.node;
            r_entry.prev_hop <= i_query.hop;
            r_entry.seq      <= i_query.seq;
            r_entry.hops     <= i_query.hops;
        end else if (i_shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
`default_nettype wire

>>> rtl/pdrt_pick.sv
// One registered node of the search tree: keeps the lower-index hit of two.
// Uses pdrt_pkg for the hit type.
`default_nettype none
module pdrt_pick #(
    parameter int IW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pdrt_pkg::t_hit i_lo_hit,
    input  wire logic [IW-1:0] i_lo_idx,
    input  wire pdrt_pkg::t_hit i_hi_hit,
    input  wire logic [IW-1:0] i_hi_idx,
    output pdrt_pkg::t_hit     o_hit,
    output logic [IW-1:0]      o_idx
);

    logic          r_found;
    logic [15:0]   r_addr;
    logic [7:0]    r_hops;
    logic [IW-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= i_lo_hit.found || i_hi_hit.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lo_hit.found) begin
            r_addr <= i_lo_hit.addr;
            r_hops <= i_lo_hit.hops;
            r_idx  <= i_lo_idx;
        end else begin
            r_addr <= i_hi_hit.addr;
            r_hops <= i_hi_hit.hops;
            r_idx  <= i_hi_idx;
        end
    end

    assign o_hit = '{found: r_found, addr: r_addr, hops: r_hops};
    assign o_idx = r_idx;

endmodule
`default_nettype wire

>>> tb/pdrt_reply_checker.sv
// Result checker for packet_duplicate_route_table: watches the command and result
// channels, keeps a shadow copy of the route table and checks results in order.
// Depends on pdrt_pkg for the command, status and entry types.
module pdrt_reply_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_node_addr,
    input  wire logic [15:0] i_last_hop,
    input  wire logic [31:0] i_seq_num,
    input  wire logic [7:0]  i_hop_count,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [15:0] i_out_addr,
    input  wire logic [7:0]  i_out_hops,
    input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0] i_entry_count,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results,
    output int               o_full_refusals,
    output int               o_peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdrt_pkg::*;

    localparam int COUNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        addr;
        logic [7:0]         hops;
        logic [COUNT_W-1:0] count;
    } t_reply;

    t_entry routes [TABLE_ENTRIES];
    int     route_fill;
    t_reply pending_replies [$];
    t_query seen_cmd;
    t_reply want;
    t_reply predicted;
    int     fail_count;
    int     result_count;
    int     full_refusals;
    int     peak_fill;
    int     queued;

    assign o_fail_count    = fail_count;
    assign o_pending       = queued;
    assign o_results       = result_count;
    assign o_full_refusals = full_refusals;
    assign o_peak_fill     = peak_fill;

    initial begin
        route_fill    = 0;
        fail_count    = 0;
        result_count  = 0;
        full_refusals = 0;
        peak_fill     = 0;
        queued        = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] wanted);
        begin
            if (fail_count < MAX_PRINTED)
                $display("%0t ns: result %0d %s: got 0x%0h, predicted 0x%0h",
                         $time, result_count, field, got, wanted);
            fail_count++;
        end
    endtask

    task automatic apply_route_cmd(input t_query q, output t_reply r);
        int     at;
        int     first;
        t_entry fresh;
        begin
            r        = '0;
            r.status = ST_MISS;
            at       = -1;
            first    = -1;
            for (int k = 0; k < route_fill; k++) begin
                if (at < 0 && routes[k].node == q.node && routes[k].seq == q.seq)
                    at = k;
            end
            case (q.cmd)
                CMD_INSERT: begin
                    if (at >= 0) begin
                        r.status = ST_MISS;
                    end else if (route_fill >= TABLE_ENTRIES) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        fresh.node         = q.node;
                        fresh.prev_hop     = q.hop;
                        fresh.seq          = q.seq;
                        fresh.hops         = q.hops;
                        routes[route_fill] = fresh;
                        route_fill++;
                        r.status = ST_OK;
                    end
                end
                CMD_REMOVE: begin
                    if (at >= 0) begin
                        for (int k = at; k < route_fill - 1; k++)
                            routes[k] = routes[k + 1];
                        route_fill--;
                        r.status = ST_OK;
                    end
                end
                CMD_FIND: begin
                    if (at >= 0) begin
                        r.addr   = routes[at].prev_hop;
                        r.hops   = routes[at].hops;
                        r.status = ST_OK;
                    end
                end
                CMD_HOP_OF_NODE: begin
                    for (int k = 0; k < route_fill; k++) begin
                        if (first < 0 && routes[k].node == q.node)
                            first = k;
                    end
                    if (first >= 0) begin
                        r.addr   = routes[first].prev_hop;
                        r.status = ST_OK;
                    end
                end
                CMD_NODE_OF_HOP: begin
                    for (int k = 0; k < route_fill; k++) begin
                        if (first < 0 && routes[k].prev_hop == q.hop)
                            first = k;
                    end
                    if (first >= 0) begin
                        r.addr   = routes[first].node;
                        r.status = ST_OK;
                    end
                end
                default: begin
                end
            endcase
            r.count = COUNT_W'(route_fill);
            if (route_fill > peak_fill)
                peak_fill = route_fill;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            route_fill = 0;
            pending_replies.delete();
            queued = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (pending_replies.size() == 0) begin
                    report_mismatch("arrived with no command outstanding", 1, 0);
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_out_addr !== want.addr)
                        report_mismatch("out_addr", i_out_addr, want.addr);
                    if (i_out_hops !== want.hops)
                        report_mismatch("out_hops", i_out_hops, want.hops);
                    if (i_entry_count !== want.count)
                        report_mismatch("entry_count", i_entry_count, want.count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                seen_cmd.cmd  = i_cmd;
                seen_cmd.node = i_node_addr;
                seen_cmd.hop  = i_last_hop;
                seen_cmd.seq  = i_seq_num;
                seen_cmd.hops = i_hop_count;
                apply_route_cmd(seen_cmd, predicted);
                pending_replies.push_back(predicted);
            end
            queued = pending_replies.size();
        end
    end

endmodule

>>> tb/tb_packet_duplicate_route_table.sv
// Testbench top for packet_duplicate_route_table: drives directed and random
// table commands with random idling on both channels and gives the verdict.
// Depends on pdrt_pkg, the block and pdrt_reply_checker.
module tb_packet_duplicate_route_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pdrt_pkg::*;

    localparam int TABLE_ENTRIES     = 64;
    localparam int COUNT_W           = $clog2(TABLE_ENTRIES + 1);
    localparam int RESET_CYCLES      = 12;
    localparam int SEGMENTS          = 8;
    localparam int ITEMS_PER_SEGMENT = 125;
    localparam int LONG_HOLD_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES      = 20;

    localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         cmd;
    logic [15:0]        node_addr;
    logic [15:0]        last_hop;
    logic [31:0]        seq_num;
    logic [7:0]         hop_count;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [15:0]        out_addr;
    logic [7:0]         out_hops;
    logic [COUNT_W-1:0] entry_count;

    int fail_count;
    int pending;
    int results;
    int full_refusals;
    int peak_fill;

    int          idle_pct;
    bit          long_hold_req;
    bit          long_hold_done;
    int          stall_left;
    int          cmd_tally [8];
    logic [15:0] node_pool [8];
    logic [15:0] hop_pool [8];
    logic [31:0] seq_pool [16];

    packet_duplicate_route_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_node_addr   (node_addr),
        .i_last_hop    (last_hop),
        .i_seq_num     (seq_num),
        .i_hop_count   (hop_count),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_out_addr    (out_addr),
        .o_out_hops    (out_hops),
        .o_entry_count (entry_count)
    );

    pdrt_reply_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_replies (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_node_addr     (node_addr),
        .i_last_hop      (last_hop),
        .i_seq_num       (seq_num),
        .i_hop_count     (hop_count),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_out_addr      (out_addr),
        .i_out_hops      (out_hops),
        .i_entry_count   (entry_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_full_refusals (full_refusals),
        .o_peak_fill     (peak_fill)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stall bursts plus one long hold to back the block up
    initial begin
        out_stall      = 1'b0;
        stall_left     = 0;
        long_hold_done = 1'b0;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            out_stall      <= 1'b1;
            stall_left     <= LONG_HOLD_CYCLES - 1;
            long_hold_done <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[packet_duplicate_route_table] ERROR");
        $finish;
    end

    function automatic logic [15:0] pick_node(input bit wild);
        if (wild && $urandom_range(0, 7) == 0)
            return 16'($urandom);
        return node_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [15:0] pick_hop(input bit wild);
        if (wild && $urandom_range(0, 7) == 0)
            return 16'($urandom);
        return hop_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [31:0] pick_seq(input bit wild);
        if (wild && $urandom_range(0, 7) == 0)
            return $urandom;
        return seq_pool[$urandom_range(0, 15)];
    endfunction

    task automatic issue_cmd(input logic [2:0] c, input logic [15:0] node,
                             input logic [15:0] hop, input logic [31:0] seq,
                             input logic [7:0] hops);
        int gap;
        begin
            @(negedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                gap = $urandom_range(1, 19);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  <= 1'b1;
            cmd       <= c;
            node_addr <= node;
            last_hop  <= hop;
            seq_num   <= seq;
            hop_count <= hops;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            cmd_tally[c]++;
        end
    endtask

    // fill phases lean on inserts, drain phases on removes; keys come from
    // small pools so lookups and removes hit, wild keys only on non-inserts
    task automatic send_random(input bit filling);
        int         r;
        logic [2:0] c;
        bit         wild;
        begin
            r = $urandom_range(0, 99);
            if (r < (filling ? 70 : 15))
                c = CMD_INSERT;
            else if (r < (filling ? 78 : 70))
                c = CMD_REMOVE;
            else if (r < (filling ? 86 : 80))
                c = CMD_FIND;
            else if (r < (filling ? 92 : 88))
                c = CMD_HOP_OF_NODE;
            else if (r < 97)
                c = CMD_NODE_OF_HOP;
            else
                c = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
            wild = (c != CMD_INSERT);
            issue_cmd(c, pick_node(wild), pick_hop(wild), pick_seq(wild),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int seg;
        int k;
        int odd_cmds;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_INSERT;
        node_addr     = '0;
        last_hop      = '0;
        seq_num       = '0;
        hop_count     = '0;
        idle_pct      = 0;
        long_hold_req = 1'b0;
        odd_cmds      = 0;
        for (k = 0; k < 8; k++) begin
            cmd_tally[k] = 0;
            node_pool[k] = 16'($urandom);
            hop_pool[k]  = 16'($urandom);
        end
        for (k = 0; k < 16; k++)
            seq_pool[k] = $urandom;
        node_pool[0] = 16'h0000;
        node_pool[1] = 16'hFFFF;
        node_pool[2] = 16'h0001;
        hop_pool[0]  = 16'h0000;
        hop_pool[1]  = 16'hFFFF;
        seq_pool[0]  = 32'h0000_0000;
        seq_pool[1]  = 32'hFFFF_FFFF;
        seq_pool[2]  = 32'h0000_0007;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 10;
        issue_cmd(CMD_FIND,        16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_HOP_OF_NODE, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_NODE_OF_HOP, 16'h0000, 16'hFFFF, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_INSERT,      16'h0000, 16'hFFFF, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_INSERT,      16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'hFF);
        issue_cmd(CMD_INSERT,      16'h0000, 16'h1234, 32'hFFFF_FFFF, 8'h5A);
        issue_cmd(CMD_INSERT,      16'h0001, 16'hFFFF, 32'h0000_0007, 8'h01);
        issue_cmd(CMD_INSERT,      16'h0000, 16'h0BAD, 32'h0000_0000, 8'h03);
        issue_cmd(CMD_FIND,        16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'h00);
        issue_cmd(CMD_FIND,        16'h0000, 16'h0000, 32'h0000_0001, 8'h00);
        issue_cmd(CMD_HOP_OF_NODE, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_NODE_OF_HOP, 16'h0000, 16'hFFFF, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_REMOVE,      16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_HOP_OF_NODE, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_NODE_OF_HOP, 16'h0000, 16'hFFFF, 32'h0000_0000, 8'h00);
        issue_cmd(CMD_REMOVE,      16'h0000, 16'h0000, 32'h0000_0001, 8'h00);
        for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++)
            issue_cmd(3'(c), 16'h0001, 16'hFFFF, 32'h0000_0007, 8'hFF);
        issue_cmd(CMD_REMOVE,      16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'h00);
        issue_cmd(CMD_FIND,        16'h0001, 16'h0000, 32'h0000_0007, 8'h00);
        issue_cmd(CMD_FIND,        16'h0000, 16'h0000, 32'hFFFF_FFFF, 8'h00);
        issue_cmd(CMD_NODE_OF_HOP, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS - 1) begin
                idle_pct = 0;
            end else if (seg == 0) begin
                idle_pct = 15;
            end else begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 15;
                    default: idle_pct = 35;
                endcase
            end
            if (seg == 1)
                long_hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_SEGMENT; k++)
                send_random(seg % 2 == 0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++)
            odd_cmds += cmd_tally[c];
        $display("Covered %0d inserts, %0d removes, %0d finds, %0d lookups, %0d unknown cmds.",
                 cmd_tally[CMD_INSERT], cmd_tally[CMD_REMOVE], cmd_tally[CMD_FIND],
                 cmd_tally[CMD_HOP_OF_NODE] + cmd_tally[CMD_NODE_OF_HOP], odd_cmds);
        $display("Checked %0d results; table peaked at %0d entries, %0d inserts refused full.",
                 results, peak_fill, full_refusals);
        if (fail_count == 0 && pending == 0)
            $display("[packet_duplicate_route_table] OK");
        else
            $display("[packet_duplicate_route_table] ERROR");
        $finish;
    end

endmodule
